[rtl/core/gqe_pkg.sv]
// shared types, constants and helper functions for the glyph quad emitter
package gqe_pkg;

	localparam int DEF_VERTEX_BUDGET = 6144;
	localparam int DEF_ATLAS_COLUMNS = 16;
	localparam int DEF_ATLAS_ROWS    = 6;

	localparam logic [7:0] GLYPH_FIRST  = 8'd32;
	localparam logic [7:0] GLYPH_LAST   = 8'd126;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam int GLYPH_COUNT     = 95;
	localparam int VERTS_PER_GLYPH = 6;

	localparam int POS_W    = 16;
	localparam int METRIC_W = 6;
	localparam int SCALE_W  = 12;
	localparam int SIZE_W   = 14;
	localparam int COLOUR_W = 32;
	localparam int UV_W     = 17;
	localparam int UV_ONE   = 65536;
	localparam int PROD_W   = METRIC_W + SCALE_W;

	localparam logic [METRIC_W-1:0] RST_CELL_W  = 6'd9;
	localparam logic [METRIC_W-1:0] RST_CELL_H  = 6'd19;
	localparam logic [METRIC_W-1:0] RST_ADVANCE = 6'd8;

	typedef logic [2:0] vidx_t;
	localparam vidx_t VERT_LAST = 3'd5;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_CHAR  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CFG_CELL_W  = 2'd0,
		CFG_CELL_H  = 2'd1,
		CFG_ADVANCE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [METRIC_W-1:0] cell_w;
		logic [METRIC_W-1:0] cell_h;
		logic [METRIC_W-1:0] advance;
	} cfg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x0;
		logic signed [POS_W-1:0] y0;
		logic signed [POS_W-1:0] x1;
		logic signed [POS_W-1:0] y1;
		logic [UV_W-1:0]         u0;
		logic [UV_W-1:0]         u1;
		logic [UV_W-1:0]         v0;
		logic [UV_W-1:0]         v1;
		logic [COLOUR_W-1:0]     colour;
	} quad_t;

	// metric times Q4.8 scale, rounded to Q.4
	function automatic logic [SIZE_W-1:0] scaled_size(input logic [METRIC_W-1:0] px,
			input logic [SCALE_W-1:0] scl);
		logic [PROD_W-1:0] p;
		p = PROD_W'(px) * PROD_W'(scl) + PROD_W'(8);
		return p[PROD_W-1:4];
	endfunction

	// signed position plus unsigned size, saturating at the positive limit
	function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
			input logic [SIZE_W-1:0] d);
		logic [POS_W:0] s;
		s = {a[POS_W-1], a} + {{(POS_W+1-SIZE_W){1'b0}}, d};
		if (!s[POS_W] && s[POS_W-1]) begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end
		return s[POS_W-1:0];
	endfunction

endpackage

[rtl/core/glyph_quad_emitter.sv]
// top level of the glyph quad emitter: cell metric registers and the two stages
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid / in_ready   | action, origin_x/y, scale, colour, char_code
//  out     | source    | out_valid / out_ready | vert_x/y, tex_u/v, vert_colour, last_vertex
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// an item is held in the input register; begin line, clear, newline, non-printable
// and over-budget glyph items retire there, one per cycle
// a printable glyph within the vertex budget moves into the quad buffer and leaves
// as six vertex transfers through the single vertex output port
// reset clears pen, sizes, colour, budget count and the cell metrics to defaults
// a stalled output holds the quad buffer, which then holds the input register
module glyph_quad_emitter #(
	parameter int VERTEX_BUDGET = gqe_pkg::DEF_VERTEX_BUDGET,
	parameter int ATLAS_COLUMNS = gqe_pkg::DEF_ATLAS_COLUMNS,
	parameter int ATLAS_ROWS    = gqe_pkg::DEF_ATLAS_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          action,
	input  logic signed [gqe_pkg::POS_W-1:0]    origin_x,
	input  logic signed [gqe_pkg::POS_W-1:0]    origin_y,
	input  logic [gqe_pkg::SCALE_W-1:0]         scale,
	input  logic [gqe_pkg::COLOUR_W-1:0]        colour,
	input  logic [7:0]                          char_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gqe_pkg::POS_W-1:0]    vert_x,
	output logic signed [gqe_pkg::POS_W-1:0]    vert_y,
	output logic [gqe_pkg::UV_W-1:0]            tex_u,
	output logic [gqe_pkg::UV_W-1:0]            tex_v,
	output logic [gqe_pkg::COLOUR_W-1:0]        vert_colour,
	output logic                                last_vertex,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [gqe_pkg::METRIC_W-1:0]        cfg_data
);
	import gqe_pkg::*;

	cfg_t   cfg_q;
	logic   quad_valid;
	logic   quad_ready;
	quad_t  quad;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_w  <= RST_CELL_W;
			cfg_q.cell_h  <= RST_CELL_H;
			cfg_q.advance <= RST_ADVANCE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CELL_W:  cfg_q.cell_w  <= cfg_data;
				CFG_CELL_H:  cfg_q.cell_h  <= cfg_data;
				CFG_ADVANCE: cfg_q.advance <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gqe_glyph #(
		.VERTEX_BUDGET (VERTEX_BUDGET),
		.ATLAS_COLUMNS (ATLAS_COLUMNS),
		.ATLAS_ROWS    (ATLAS_ROWS)
	) u_glyph (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.scale      (scale),
		.colour     (colour),
		.char_code  (char_code),
		.quad_valid (quad_valid),
		.quad_ready (quad_ready),
		.quad       (quad)
	);

	gqe_vtx_out u_vtx_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.quad_valid  (quad_valid),
		.quad_ready  (quad_ready),
		.quad        (quad),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.vert_colour (vert_colour),
		.last_vertex (last_vertex)
	);

	// input only stalls behind a glyph waiting for the quad buffer
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> quad_valid)
		else $error("input stalled without a pending glyph");

	// a waiting glyph keeps its corners until the buffer takes it
	a_quad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quad_valid && !quad_ready |=> quad_valid && $stable(quad))
		else $error("pending glyph changed before transfer");

	// a glyph always delivers all six vertices
	a_quad_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_vertex |=> out_valid)
		else $error("glyph ended before its last vertex");

	// output goes idle after the last vertex unless a new glyph was loaded
	a_quad_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_vertex && !quad_valid |=> !out_valid)
		else $error("vertex emitted after the last one of a glyph");

endmodule

[rtl/core/gqe_glyph.sv]
// input register, pen and budget state, and quad corner and uv computation
module gqe_glyph #(
	parameter int VERTEX_BUDGET = gqe_pkg::DEF_VERTEX_BUDGET,
	parameter int ATLAS_COLUMNS = gqe_pkg::DEF_ATLAS_COLUMNS,
	parameter int ATLAS_ROWS    = gqe_pkg::DEF_ATLAS_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gqe_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          action,
	input  logic signed [gqe_pkg::POS_W-1:0]    origin_x,
	input  logic signed [gqe_pkg::POS_W-1:0]    origin_y,
	input  logic [gqe_pkg::SCALE_W-1:0]         scale,
	input  logic [gqe_pkg::COLOUR_W-1:0]        colour,
	input  logic [7:0]                          char_code,
	output logic                                quad_valid,
	input  logic                                quad_ready,
	output gqe_pkg::quad_t                      quad
);
	import gqe_pkg::*;

	localparam int USED_W = $clog2(VERTEX_BUDGET + 1);
	localparam int IDX_W  = $clog2(GLYPH_COUNT);
	localparam int USTEP  = (UV_ONE + ATLAS_COLUMNS / 2) / ATLAS_COLUMNS;
	localparam int VSTEP  = (UV_ONE + ATLAS_ROWS / 2) / ATLAS_ROWS;

	// atlas uv corners per glyph, fixed at elaboration
	logic [UV_W-1:0] u0_tbl [GLYPH_COUNT];
	logic [UV_W-1:0] u1_tbl [GLYPH_COUNT];
	logic [UV_W-1:0] v0_tbl [GLYPH_COUNT];
	logic [UV_W-1:0] v1_tbl [GLYPH_COUNT];

	for (genvar g = 0; g < GLYPH_COUNT; g++) begin : g_uv
		localparam int U0 = (g % ATLAS_COLUMNS) * USTEP;
		localparam int V0 = (g / ATLAS_COLUMNS) * VSTEP;
		localparam int U1 = U0 + USTEP;
		localparam int V1 = V0 + VSTEP;
		assign u0_tbl[g] = UV_W'((U0 > UV_ONE) ? UV_ONE : U0);
		assign u1_tbl[g] = UV_W'((U1 > UV_ONE) ? UV_ONE : U1);
		assign v0_tbl[g] = UV_W'((V0 > UV_ONE) ? UV_ONE : V0);
		assign v1_tbl[g] = UV_W'((V1 > UV_ONE) ? UV_ONE : V1);
	end

	logic                       valid_s1;
	logic [1:0]                 act_s1;
	logic signed [POS_W-1:0]    ox_s1;
	logic signed [POS_W-1:0]    oy_s1;
	logic [SCALE_W-1:0]         scl_s1;
	logic [COLOUR_W-1:0]        col_s1;
	logic [7:0]                 chr_s1;

	logic signed [POS_W-1:0]    pen_x_q;
	logic signed [POS_W-1:0]    pen_y_q;
	logic signed [POS_W-1:0]    line_x_q;
	logic [SIZE_W-1:0]          adv_q;
	logic [SIZE_W-1:0]          qw_q;
	logic [SIZE_W-1:0]          qh_q;
	logic [COLOUR_W-1:0]        colour_q;
	logic [USED_W-1:0]          used_q;

	logic                       is_newline;
	logic                       is_print;
	logic                       budget_ok;
	logic                       emit;
	logic                       consume;
	logic [IDX_W-1:0]           gidx;

	assign is_newline = (chr_s1 == NEWLINE_BYTE);
	assign is_print   = (chr_s1 >= GLYPH_FIRST) && (chr_s1 <= GLYPH_LAST);
	assign budget_ok  = ({1'b0, used_q} + (USED_W+1)'(VERTS_PER_GLYPH))
		<= (USED_W+1)'(VERTEX_BUDGET);
	assign emit       = valid_s1 && (act_s1 == ACT_CHAR) && !is_newline && is_print && budget_ok;
	assign consume    = valid_s1 && (!emit || quad_ready);
	assign in_ready   = !valid_s1 || consume;
	assign quad_valid = emit;

	assign gidx = IDX_W'(chr_s1 - GLYPH_FIRST);

	always_comb begin
		quad.x0     = pen_x_q;
		quad.y0     = pen_y_q;
		quad.x1     = sat_add(pen_x_q, qw_q);
		quad.y1     = sat_add(pen_y_q, qh_q);
		quad.u0     = u0_tbl[gidx];
		quad.u1     = u1_tbl[gidx];
		quad.v0     = v0_tbl[gidx];
		quad.v1     = v1_tbl[gidx];
		quad.colour = colour_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s1 <= action;
			ox_s1  <= origin_x;
			oy_s1  <= origin_y;
			scl_s1 <= scale;
			col_s1 <= colour;
			chr_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			line_x_q <= '0;
			adv_q    <= '0;
			qw_q     <= '0;
			qh_q     <= '0;
			colour_q <= '0;
			used_q   <= '0;
		end else if (consume) begin
			unique case (act_s1)
				ACT_BEGIN: begin
					pen_x_q  <= ox_s1;
					pen_y_q  <= oy_s1;
					line_x_q <= ox_s1;
					colour_q <= col_s1;
					adv_q    <= scaled_size(cfg.advance, scl_s1);
					qw_q     <= scaled_size(cfg.cell_w, scl_s1);
					qh_q     <= scaled_size(cfg.cell_h, scl_s1);
				end
				ACT_CHAR: begin
					if (is_newline) begin
						pen_x_q <= line_x_q;
						pen_y_q <= sat_add(pen_y_q, qh_q);
					end else if (!is_print) begin
						pen_x_q <= sat_add(pen_x_q, adv_q);
					end else if (budget_ok) begin
						pen_x_q <= sat_add(pen_x_q, adv_q);
						used_q  <= used_q + USED_W'(VERTS_PER_GLYPH);
					end
				end
				ACT_CLEAR: begin
					used_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/gqe_vtx_out.sv]
// quad buffer that walks the six vertices of a glyph out one per transfer
module gqe_vtx_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                quad_valid,
	output logic                                quad_ready,
	input  gqe_pkg::quad_t                      quad,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gqe_pkg::POS_W-1:0]    vert_x,
	output logic signed [gqe_pkg::POS_W-1:0]    vert_y,
	output logic [gqe_pkg::UV_W-1:0]            tex_u,
	output logic [gqe_pkg::UV_W-1:0]            tex_v,
	output logic [gqe_pkg::COLOUR_W-1:0]        vert_colour,
	output logic                                last_vertex
);
	import gqe_pkg::*;

	quad_t  quad_q;
	logic   busy_q;
	vidx_t  cnt_q;
	logic   use_x1;
	logic   use_y1;

	assign out_valid  = busy_q;
	assign quad_ready = !busy_q || (out_ready && (cnt_q == VERT_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (quad_valid && quad_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (cnt_q == VERT_LAST) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + vidx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (quad_valid && quad_ready) begin
			quad_q <= quad;
		end
	end

	// triangle order: (0,0) (1,0) (0,1) (0,1) (1,0) (1,1)
	always_comb begin
		case (cnt_q) inside
			3'd1, 3'd4, 3'd5: use_x1 = 1'b1;
			default:          use_x1 = 1'b0;
		endcase
		case (cnt_q) inside
			3'd2, 3'd3, 3'd5: use_y1 = 1'b1;
			default:          use_y1 = 1'b0;
		endcase
	end

	assign vert_x      = use_x1 ? quad_q.x1 : quad_q.x0;
	assign vert_y      = use_y1 ? quad_q.y1 : quad_q.y0;
	assign tex_u       = use_x1 ? quad_q.u1 : quad_q.u0;
	assign tex_v       = use_y1 ? quad_q.v1 : quad_q.v0;
	assign vert_colour = quad_q.colour;
	assign last_vertex = (cnt_q == VERT_LAST);

endmodule
